>>> rtl/igsr_pkg.sv
`default_nettype none

package igsr_pkg;

    // Fixed field widths of the item and result words.
    localparam int DATA_W = 64;
    localparam int KIND_W = 3;
    localparam int NODE_W = 9;
    localparam int COMP_W = 2;
    localparam int OP_W   = 2;
    localparam int CNT_W  = 3;

    // Configuration port geometry.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Default store geometry.
    localparam int MAX_NODES_DEF      = 512;
    localparam int MAX_COMPONENTS_DEF = 4;

    typedef logic [DATA_W-1:0] t_word;

endpackage

`default_nettype wire

>>> rtl/igsr_ram.sv
`default_nettype none

// Single-port synchronous RAM with a registered read.
module igsr_ram #(
    parameter int WIDTH = igsr_pkg::DATA_W,
    parameter int DEPTH = igsr_pkg::MAX_NODES_DEF * igsr_pkg::MAX_COMPONENTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/igsr_mul64.sv
`default_nettype none

// Low 64 bits of a 64 x 64 product, built from three 32 x 32 partial
// products on one shared multiplier. The high x high term never reaches
// the low word and is skipped. o_done pulses for one cycle with the result.
module igsr_mul64 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  igsr_pkg::t_word     i_a,
    input  igsr_pkg::t_word     i_b,
    output logic                o_done,
    output igsr_pkg::t_word     o_product
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LL,
        PH_LH,
        PH_HL
    } t_phase;

    t_phase          r_phase;
    igsr_pkg::t_word r_a;
    igsr_pkg::t_word r_b;
    igsr_pkg::t_word r_lo;
    logic [31:0]     r_cross;
    igsr_pkg::t_word r_product;
    logic            r_done;

    logic [31:0]     w_x;
    logic [31:0]     w_y;
    logic [63:0]     w_prod;

    assign w_x    = (r_phase == PH_HL) ? r_a[63:32] : r_a[31:0];
    assign w_y    = (r_phase == PH_LH) ? r_b[63:32] : r_b[31:0];
    assign w_prod = {32'b0, w_x} * {32'b0, w_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_phase <= PH_LL;
                    end
                end
                PH_LL: begin
                    r_lo    <= w_prod;
                    r_phase <= PH_LH;
                end
                PH_LH: begin
                    r_cross <= w_prod[31:0];
                    r_phase <= PH_HL;
                end
                PH_HL: begin
                    r_product <= r_lo + {r_cross + w_prod[31:0], 32'b0};
                    r_done    <= 1'b1;
                    r_phase   <= PH_IDLE;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_product = r_product;

endmodule

`default_nettype wire

>>> rtl/indexed_gather_scatter_reduce.sv
// One word is worked on at a time: o_in_stall holds new words off until the
// sequencer is idle again; the pace is set by the RAM read turnaround and the
// shared 32x32 multiplier of the multiply unit. A result passes through a
// pending result register into the output register. Reset (synchronous,
// active low) clears the control state, the accumulator, the held row value,
// the configuration and the valid flags; the vector store is not cleared.
`default_nettype none

module indexed_gather_scatter_reduce #(
    parameter int MAX_NODES      = igsr_pkg::MAX_NODES_DEF,
    parameter int MAX_COMPONENTS = igsr_pkg::MAX_COMPONENTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Item channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [igsr_pkg::KIND_W-1:0]       i_kind,
    input  logic [igsr_pkg::NODE_W-1:0]       i_node_id,
    input  logic [igsr_pkg::COMP_W-1:0]       i_component,
    input  logic signed [igsr_pkg::DATA_W-1:0] i_value,
    input  logic                              i_last,

    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [igsr_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_bad_address,

    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [igsr_pkg::APB_AW-1:0]       paddr,
    input  logic [igsr_pkg::APB_DW-1:0]       pwdata,
    output logic [igsr_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    // Item kinds and reduction operations.
    localparam logic [igsr_pkg::KIND_W-1:0] KIND_WRITE   = 3'd0;
    localparam logic [igsr_pkg::KIND_W-1:0] KIND_GATHER  = 3'd1;
    localparam logic [igsr_pkg::KIND_W-1:0] KIND_SCATTER = 3'd2;
    localparam logic [igsr_pkg::KIND_W-1:0] KIND_READ    = 3'd3;
    localparam logic [igsr_pkg::KIND_W-1:0] KIND_EMPTY   = 3'd4;

    localparam logic [igsr_pkg::OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [igsr_pkg::OP_W-1:0] OP_MUL = 2'd1;
    localparam logic [igsr_pkg::OP_W-1:0] OP_MAX = 2'd2;
    localparam logic [igsr_pkg::OP_W-1:0] OP_MIN = 2'd3;

    localparam logic REG_REDUCE_OP  = 1'b0;
    localparam logic REG_COMPONENTS = 1'b1;

    // Store geometry.
    localparam int DEPTH  = MAX_NODES * MAX_COMPONENTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int NODE_L = $clog2(MAX_NODES);

    // The node index is reduced modulo MAX_NODES with a reciprocal multiply:
    // q = (node * RECIP) >> SH is the exact quotient for every 9-bit node.
    localparam int SH      = igsr_pkg::NODE_W + NODE_L;
    localparam int RECIP   = ((1 << SH) + MAX_NODES - 1) / MAX_NODES;
    localparam int RECIP_W = igsr_pkg::NODE_W + 2;
    localparam int QP_W    = igsr_pkg::NODE_W + RECIP_W;

    // Effective components per node never exceeds what the register can hold.
    localparam int K_MAX = (MAX_COMPONENTS > 7) ? 7 : MAX_COMPONENTS;
    localparam int MK_W  = NODE_L + 4;
    localparam int NK_W  = igsr_pkg::NODE_W + igsr_pkg::CNT_W;
    localparam int AP_W  = igsr_pkg::NODE_W + MK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_DATA,
        S_MUL,
        S_EMIT
    } t_state;

    // Configuration registers.
    logic [igsr_pkg::OP_W-1:0]  r_reduce_op;
    logic [igsr_pkg::CNT_W-1:0] r_components;
    logic [igsr_pkg::CNT_W-1:0] w_eff_k;
    logic [MK_W-1:0]            r_mk;
    logic                       w_cfg_wr;

    // Sequencer and the item being worked on.
    t_state                     r_state;
    t_state                     n_state;
    logic [igsr_pkg::KIND_W-1:0] r_kind;
    igsr_pkg::t_word            r_value;
    logic                       r_last;
    logic                       r_bad;
    logic [NK_W-1:0]            r_nk;
    logic [igsr_pkg::NODE_W-1:0] r_q;

    // Architectural reduction state.
    igsr_pkg::t_word            r_acc;
    logic                       r_row_open;
    igsr_pkg::t_word            r_held;

    // Pending result and output register.
    logic                       r_res_en;
    igsr_pkg::t_word            r_res_value;
    logic                       r_res_bad;
    logic                       r_out_valid;
    igsr_pkg::t_word            r_out_value;
    logic                       r_out_bad;

    logic                       w_in_acc;
    logic                       w_out_free;
    logic                       w_bad_in;
    logic [QP_W-1:0]            w_qprod;
    logic [AP_W-1:0]            w_addr_full;
    logic [AW-1:0]              w_addr;
    logic                       w_mem_we;
    logic                       w_mem_re;
    igsr_pkg::t_word            w_mem_wdata;
    igsr_pkg::t_word            w_rdata;
    igsr_pkg::t_word            w_identity;
    igsr_pkg::t_word            w_acc_start;
    igsr_pkg::t_word            w_alu;
    igsr_pkg::t_word            w_comb;
    logic                       w_fin;
    logic                       w_mul_start;
    logic                       w_mul_done;
    igsr_pkg::t_word            w_mul_product;

    function automatic igsr_pkg::t_word f_identity(input logic [igsr_pkg::OP_W-1:0] op);
        igsr_pkg::t_word id;
        unique case (op)
            OP_ADD:  id = 64'd0;
            OP_MUL:  id = 64'd1;
            OP_MAX:  id = 64'h8000_0000_0000_0000;
            OP_MIN:  id = 64'h7FFF_FFFF_FFFF_FFFF;
            default: id = 64'd0;
        endcase
        return id;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high, so no access is extended by wait states.
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_COMPONENTS) ? igsr_pkg::APB_DW'(r_components)
                                                   : igsr_pkg::APB_DW'(r_reduce_op);

    // A components value of zero acts as one, and values above K_MAX (the
    // smaller of MAX_COMPONENTS and 7) act as K_MAX.
    always_comb begin
        if (r_components == 3'd0) begin
            w_eff_k = 3'd1;
        end else if (r_components > 3'(K_MAX)) begin
            w_eff_k = 3'(K_MAX);
        end else begin
            w_eff_k = r_components;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reduce_op  <= OP_ADD;
            r_components <= 3'd1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_REDUCE_OP) begin
                r_reduce_op <= pwdata[igsr_pkg::OP_W-1:0];
            end else begin
                r_components <= pwdata[igsr_pkg::CNT_W-1:0];
            end
        end
    end

    // Words per node times the node count, used to fold the node index back
    // into range. It follows the components register in the next cycle, which
    // is before any accepted word reaches the address stage.
    always_ff @(posedge i_clk) begin
        r_mk <= MK_W'(MAX_NODES) * MK_W'(w_eff_k);
    end

    // ------------------------------------------------------------------
    // Address generation. At acceptance the word registers node * k + comp
    // and the node quotient; the address stage subtracts quotient times the
    // node count times k, which is the same as taking the node modulo
    // MAX_NODES first.
    // ------------------------------------------------------------------
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_bad_in    = ({1'b0, i_component} >= w_eff_k);
    assign w_qprod     = QP_W'(i_node_id) * QP_W'(RECIP);
    assign w_addr_full = AP_W'(r_nk) - AP_W'(r_q) * AP_W'(r_mk);
    assign w_addr      = w_addr_full[AW-1:0];

    // The store is touched only in the address stage, and only at a good
    // component. Writes and scatters finish there; reads and gathers get
    // their word in the next cycle.
    assign w_mem_we = (r_state == S_ADDR) && !r_bad &&
                      ((r_kind == KIND_WRITE) || (r_kind == KIND_SCATTER));
    assign w_mem_re = (r_state == S_ADDR) && !r_bad &&
                      ((r_kind == KIND_GATHER) || (r_kind == KIND_READ));
    assign w_mem_wdata = (r_kind == KIND_WRITE) ? r_value : r_held;

    igsr_ram #(
        .WIDTH (igsr_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Reduction. The first gather of a row starts from the identity of the
    // current operation. Add, maximum and minimum finish in the data cycle;
    // multiply goes through the three-step multiply unit.
    // ------------------------------------------------------------------
    assign w_identity  = f_identity(r_reduce_op);
    assign w_acc_start = r_row_open ? r_acc : w_identity;

    always_comb begin
        unique case (r_reduce_op)
            OP_ADD:  w_alu = w_acc_start + w_rdata;
            OP_MAX:  w_alu = ($signed(w_rdata) > $signed(w_acc_start)) ? w_rdata : w_acc_start;
            OP_MIN:  w_alu = ($signed(w_rdata) < $signed(w_acc_start)) ? w_rdata : w_acc_start;
            default: w_alu = w_acc_start;
        endcase
    end

    assign w_mul_start = (r_state == S_DATA) && (r_kind == KIND_GATHER) &&
                         (r_reduce_op == OP_MUL);

    igsr_mul64 u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_acc_start),
        .i_b       (w_rdata),
        .o_done    (w_mul_done),
        .o_product (w_mul_product)
    );

    // A good gather closes its step either in the data cycle or when the
    // multiply unit reports its product.
    assign w_comb = (r_state == S_MUL) ? w_mul_product : w_alu;
    assign w_fin  = ((r_state == S_DATA) && (r_kind == KIND_GATHER) &&
                     (r_reduce_op != OP_MUL)) ||
                    ((r_state == S_MUL) && w_mul_done);

    // The output register takes a new result when it is empty or being
    // drained in this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                if (((r_kind == KIND_GATHER) || (r_kind == KIND_READ)) && !r_bad) begin
                    n_state = S_DATA;
                end else if ((r_kind == KIND_WRITE) || (r_kind == KIND_SCATTER) ||
                             (r_kind == KIND_GATHER) || (r_kind == KIND_READ) ||
                             (r_kind == KIND_EMPTY)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DATA: begin
                n_state = w_mul_start ? S_MUL : S_EMIT;
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_res_en || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= 64'd0;
            r_row_open  <= 1'b0;
            r_held      <= 64'd0;
            r_res_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_in_acc) begin
                r_kind  <= i_kind;
                r_value <= i_value;
                r_last  <= i_last;
                r_bad   <= w_bad_in;
                r_nk    <= NK_W'(i_node_id) * NK_W'(w_eff_k) + NK_W'(i_component);
                r_q     <= igsr_pkg::NODE_W'(w_qprod >> SH);
            end

            if (r_state == S_ADDR) begin
                // Default: a bad component answers zero with the flag set.
                r_res_en    <= r_bad;
                r_res_value <= 64'd0;
                r_res_bad   <= 1'b1;
                priority if (r_kind == KIND_EMPTY) begin
                    // An empty row drops any open row and holds the identity.
                    r_held      <= w_identity;
                    r_acc       <= 64'd0;
                    r_row_open  <= 1'b0;
                    r_res_en    <= 1'b1;
                    r_res_value <= w_identity;
                    r_res_bad   <= 1'b0;
                end else if ((r_kind == KIND_GATHER) && r_bad) begin
                    // A bad gather adds nothing but still closes a row when it is last.
                    if (r_last) begin
                        r_held      <= w_acc_start;
                        r_acc       <= 64'd0;
                        r_row_open  <= 1'b0;
                        r_res_value <= w_acc_start;
                    end else begin
                        r_acc      <= w_acc_start;
                        r_row_open <= 1'b1;
                    end
                end else if ((r_kind != KIND_WRITE) && (r_kind != KIND_SCATTER) &&
                             (r_kind != KIND_GATHER) && (r_kind != KIND_READ)) begin
                    // Unused kinds have no effect at all.
                    r_res_en <= 1'b0;
                end else begin
                    r_res_en <= r_bad;
                end
            end

            if ((r_state == S_DATA) && (r_kind == KIND_READ)) begin
                r_res_en    <= 1'b1;
                r_res_value <= w_rdata;
                r_res_bad   <= 1'b0;
            end

            if (w_fin) begin
                if (r_last) begin
                    r_held      <= w_comb;
                    r_acc       <= 64'd0;
                    r_row_open  <= 1'b0;
                    r_res_en    <= 1'b1;
                    r_res_value <= w_comb;
                    r_res_bad   <= 1'b0;
                end else begin
                    r_acc      <= w_comb;
                    r_row_open <= 1'b1;
                    r_res_en   <= 1'b0;
                end
            end

            if ((r_state == S_EMIT) && r_res_en && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_value <= r_res_value;
                r_out_bad   <= r_res_bad;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_bad_address  = r_out_bad;

    // ------------------------------------------------------------------
    // Checks on the sequencer.
    // ------------------------------------------------------------------
    a_store_write_good_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (!r_bad && (r_state == S_ADDR) && !w_mem_re))
        else $error("store written outside the address stage or at a bad component");

    a_mul_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MUL))
        else $error("multiply result arrived while the sequencer was not waiting");

    a_row_closes_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin && r_last) |=> (!r_row_open && (r_acc == 64'd0)))
        else $error("row still open after its last gather");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> (r_state == S_IDLE) || (r_state == S_EMIT))
        else $error("result stage left for a working state");

endmodule

`default_nettype wire
